### src/eec_pkg.sv
package eec_pkg;

  // Curve kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_IN    = 2'd0,
    KIND_OUT   = 2'd1,
    KIND_INOUT = 2'd2
  } kind_t;

  // Width of the normalized time u (Q0.16)
  localparam int U_W = 16;

  // Table generation constants, Q30
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned LN2_Q30     = 64'd744261118;

  // Sine series term divisor (2n)(2n+1)
  function automatic longint unsigned sin_term_div(input longint unsigned x, input int n);
    case (n)
      1:       return x / 64'd6;
      2:       return x / 64'd20;
      3:       return x / 64'd42;
      4:       return x / 64'd72;
      5:       return x / 64'd110;
      6:       return x / 64'd156;
      7:       return x / 64'd210;
      8:       return x / 64'd272;
      9:       return x / 64'd342;
      default: return x / 64'd420;
    endcase
  endfunction

  // Exponential series term divisor n
  function automatic longint unsigned exp_term_div(input longint unsigned x, input int n);
    case (n)
      1:       return x;
      2:       return x / 64'd2;
      3:       return x / 64'd3;
      4:       return x / 64'd4;
      5:       return x / 64'd5;
      6:       return x / 64'd6;
      7:       return x / 64'd7;
      8:       return x / 64'd8;
      9:       return x / 64'd9;
      10:      return x / 64'd10;
      11:      return x / 64'd11;
      12:      return x / 64'd12;
      13:      return x / 64'd13;
      default: return x / 64'd14;
    endcase
  endfunction

  // round(32768 * sin(pi/2 * k / 2^ld)), saturated to 32767
  function automatic logic [14:0] sine_entry(input longint unsigned k, input int ld);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    th   = (HALF_PI_Q30 * k) >> ld;
    th2  = (th * th) >> 30;
    term = th;
    sum  = longint'(th);
    for (int n = 1; n <= 10; n++) begin
      term = sin_term_div((term * th2) >> 30, n);
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
    if (r > 64'd32767) r = 64'd32767;
    return r[14:0];
  endfunction

  // round(65536 * 2^(-j / 2^le)), Q1.16
  function automatic logic [16:0] exp_entry(input longint unsigned j, input int le);
    longint unsigned y;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    y    = (LN2_Q30 * j) >> le;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int n = 1; n <= 14; n++) begin
      term = exp_term_div((term * y) >> 30, n);
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) + (64'd1 << 13)) >> 14;
    return r[16:0];
  endfunction

endpackage

### src/eec_div.sv
// Restoring divider, one quotient bit per stage: q = floor(el * 2^16 / du), el < du
module eec_div #(
  parameter int TW = 16,
  parameter int SW = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [TW-1:0] in_el,
  input  logic [TW-1:0] in_du,
  input  logic [SW-1:0] in_sb,
  output logic          out_vld,
  output logic [eec_pkg::U_W-1:0] out_q,
  output logic [SW-1:0] out_sb
);
  import eec_pkg::*;

  logic          vld_r [U_W];
  logic [TW-1:0] rem_r [U_W];
  logic [TW-1:0] du_r  [U_W];
  logic [U_W-1:0] q_r  [U_W];
  logic [SW-1:0] sb_r  [U_W];

  for (genvar i = 0; i < U_W; i++) begin : g_step
    logic          vld_prev;
    logic [TW-1:0] rem_prev;
    logic [TW-1:0] du_prev;
    logic [U_W-1:0] q_prev;
    logic [SW-1:0] sb_prev;
    logic [TW:0]   rem2;
    logic          ge;
    logic [TW:0]   diff;

    if (i == 0) begin : g_first
      assign vld_prev = in_vld;
      assign rem_prev = in_el;
      assign du_prev  = in_du;
      assign q_prev   = '0;
      assign sb_prev  = in_sb;
    end else begin : g_next
      assign vld_prev = vld_r[i-1];
      assign rem_prev = rem_r[i-1];
      assign du_prev  = du_r[i-1];
      assign q_prev   = q_r[i-1];
      assign sb_prev  = sb_r[i-1];
    end

    // shift in a zero, trial subtract
    assign rem2 = {rem_prev, 1'b0};
    assign ge   = (rem2 >= {1'b0, du_prev});
    assign diff = rem2 - {1'b0, du_prev};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[TW-1:0] : rem2[TW-1:0];
        du_r[i]  <= du_prev;
        q_r[i]   <= {q_prev[U_W-2:0], ge};
        sb_r[i]  <= sb_prev;
      end
    end
  end

  assign out_vld = vld_r[U_W-1];
  assign out_q   = q_r[U_W-1];
  assign out_sb  = sb_r[U_W-1];

endmodule

### src/eec_rom.sv
// Quarter-wave sine ROM (Q0.15) and 2^-x fraction ROM (Q1.16), registered reads
module eec_rom #(
  parameter int SD = 1024,
  parameter int ED = 256
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [$clog2(SD):0]     sin_addr,
  input  logic [$clog2(ED)-1:0]   exp_addr,
  output logic [14:0]             sin_q_r,
  output logic [16:0]             exp_q_r
);
  import eec_pkg::*;

  localparam int LD = $clog2(SD);
  localparam int LE = $clog2(ED);

  typedef logic [14:0] sin_tab_t [SD+1];
  typedef logic [16:0] exp_tab_t [ED];

  function automatic sin_tab_t build_sin();
    sin_tab_t t;
    for (int i = 0; i <= SD; i++) t[i] = sine_entry(longint'(i), LD);
    return t;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t t;
    for (int i = 0; i < ED; i++) t[i] = exp_entry(longint'(i), LE);
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin();
  localparam exp_tab_t EXP_TAB = build_exp();

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q_r <= SIN_TAB[sin_addr];
      exp_q_r <= EXP_TAB[exp_addr];
    end
  end

endmodule

### src/elastic_easing_curve_core.sv
// Elastic easing (in / out / in-out) evaluator.
// Pipeline: 1 input stage, 16 divider stages, 9 evaluation stages, 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: rst_n synchronous, active low, clears all valid bits; tables are constant.
module elastic_easing_curve_core #(
  parameter int TIME_WIDTH       = 16,
  parameter int VALUE_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int EXP_TABLE_DEPTH  = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // elapsed, duration, start_value, change (lowest bits first), zero padded
  input  logic [((2*TIME_WIDTH+2*VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  // kind
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // eased_value, zero padded
  output logic [((VALUE_WIDTH+2+7)/8)*8-1:0] out_tdata
);
  import eec_pkg::*;

  localparam int TW   = TIME_WIDTH;
  localparam int VW   = VALUE_WIDTH;
  localparam int SD   = SINE_TABLE_DEPTH;
  localparam int ED   = EXP_TABLE_DEPTH;
  localparam int LD   = $clog2(SD);
  localparam int LE   = $clog2(ED);
  localparam int OW   = VW + 2;
  localparam int OTW  = ((OW + 7) / 8) * 8;
  localparam int SW   = 2 * VW + 4;
  localparam int NW   = 23;            // phase numerator width, offset positive
  localparam int GSW  = 35;            // g * s product
  localparam int PW   = VW + 1 + GSW;  // c * g * s product
  localparam int TMW  = VW + 3;        // rounded term
  localparam logic [23:0] RECIP3 = 24'((64'd1 << 25) / 3 + 1);
  localparam logic [23:0] RECIP9 = 24'((64'd1 << 27) / 9 + 1);

  typedef struct packed {
    logic                 inout_k;
    logic                 rising;
    logic                 zero;
    logic                 full;
    logic [3:0]           ip;
    logic signed [VW-1:0] b;
    logic signed [VW-1:0] c;
  } side_t;

  localparam int NS = 9;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- input stage: saturate time, flag ends
  logic [TW-1:0] el_in, du_in, el_sat;
  logic          in_vld_r;
  logic [TW-1:0] el_r, du_r;
  logic [SW-1:0] sb_r;

  assign el_in  = in_tdata[TW-1:0];
  assign du_in  = in_tdata[2*TW-1:TW];
  assign el_sat = (el_in > du_in) ? du_in : el_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      el_r <= el_sat;
      du_r <= du_in;
      sb_r <= {in_tuser, (el_sat == '0), (el_sat == du_in) && (el_sat != '0),
               in_tdata[2*TW+VW-1:2*TW], in_tdata[2*TW+2*VW-1:2*TW+VW]};
    end
  end

  // ---------------- divider
  logic           dv_vld;
  logic [U_W-1:0] dv_q;
  logic [SW-1:0]  dv_sb;

  eec_div #(.TW(TW), .SW(SW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_vld_r),
    .in_el  (el_r),
    .in_du  (du_r),
    .in_sb  (sb_r),
    .out_vld(dv_vld),
    .out_q  (dv_q),
    .out_sb (dv_sb)
  );

  logic [1:0] dv_kind;
  side_t      dv_side;
  assign dv_kind         = dv_sb[SW-1:SW-2];
  assign dv_side.inout_k = dv_kind[1];
  assign dv_side.rising  = 1'b0;
  assign dv_side.zero    = dv_sb[SW-3];
  assign dv_side.full    = dv_sb[SW-4];
  assign dv_side.b       = dv_sb[2*VW-1:VW];
  assign dv_side.c       = dv_sb[VW-1:0];
  assign dv_side.ip      = '0;

  logic  vld_r  [NS];
  side_t side_r [NS];

  // ---------------- stage A: signed phase v and its magnitude
  logic signed [17:0] v_nxt;
  side_t              side_a_nxt;
  logic signed [17:0] a_v_r;
  logic [16:0]        a_mag_r;

  always_comb begin
    side_a_nxt = dv_side;
    case (dv_kind)
      KIND_IN:  v_nxt = $signed({2'b00, dv_q}) - 18'sd65536;
      KIND_OUT: v_nxt = $signed({2'b00, dv_q});
      default:  v_nxt = $signed({1'b0, dv_q, 1'b0}) - 18'sd65536;
    endcase
    side_a_nxt.rising = v_nxt[17];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_a_nxt;
      a_v_r     <= v_nxt;
      a_mag_r   <= v_nxt[17] ? 17'(-v_nxt) : 17'(v_nxt);
    end
  end

  // ---------------- stage B: decay exponent split, phase numerator
  logic [19:0]        m_w;
  logic signed [24:0] vmul;
  logic signed [24:0] t_w;
  logic signed [25:0] n_w;
  side_t              side_b_nxt;
  logic [LE-1:0]      b_j_r;
  logic [NW-1:0]      b_n_r;

  always_comb begin
    m_w  = 20'(a_mag_r) * 20'd10;
    vmul = side_r[0].inout_k ? 25'(a_v_r) * 25'sd80 : 25'(a_v_r) * 25'sd40;
    t_w  = vmul >>> (U_W - LD);
    n_w  = 26'(t_w) + (side_r[0].inout_k ? 26'sd9 * 26'sd524288 : 26'sd3 * 26'sd524288);
    side_b_nxt    = side_r[0];
    side_b_nxt.ip = m_w[19:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= side_b_nxt;
      b_j_r     <= m_w[15:16-LE];
      b_n_r     <= n_w[NW-1:0];
    end
  end

  // ---------------- stage C: divide by 3 or 9 through a reciprocal
  logic [NW+23:0] c_prod_r;
  logic [LE-1:0]  c_j_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[2] <= side_r[1];
      c_prod_r  <= (NW+24)'(b_n_r) * (NW+24)'(side_r[1].inout_k ? RECIP9 : RECIP3);
      c_j_r     <= b_j_r;
    end
  end

  // ---------------- stage D: quadrant fold into table address
  logic [LD+1:0] q_w, idx_w;
  logic [LD:0]   k_w;
  logic [LD:0]   d_addr_r;
  logic          d_neg_r;
  logic [LE-1:0] d_j_r;

  always_comb begin
    q_w   = side_r[2].inout_k ? c_prod_r[27 +: LD+2] : c_prod_r[25 +: LD+2];
    idx_w = q_w - (LD+2)'(SD);
    k_w   = {1'b0, idx_w[LD-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[3] <= side_r[2];
      d_addr_r  <= idx_w[LD] ? (LD+1)'(SD) - k_w : k_w;
      d_neg_r   <= idx_w[LD+1];
      d_j_r     <= c_j_r;
    end
  end

  // ---------------- stage E: table reads
  logic [14:0] e_sin;
  logic [16:0] e_exp;
  logic        e_neg_r;

  eec_rom #(.SD(SD), .ED(ED)) u_rom (
    .clk     (clk),
    .en      (en),
    .sin_addr(d_addr_r),
    .exp_addr(d_j_r),
    .sin_q_r (e_sin),
    .exp_q_r (e_exp)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[4] <= side_r[3];
      e_neg_r   <= d_neg_r;
    end
  end

  // ---------------- stage F: g * s, signed change for the rising side
  logic signed [16:0]  s_w;
  logic signed [GSW-1:0] f_gs_r;
  logic signed [VW:0]  f_c_r;

  assign s_w = e_neg_r ? -$signed({2'b00, e_sin}) : $signed({2'b00, e_sin});

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[5] <= side_r[4];
      f_gs_r    <= GSW'($signed({1'b0, e_exp})) * GSW'(s_w);
      f_c_r     <= side_r[4].rising ? -(VW+1)'(side_r[4].c) : (VW+1)'(side_r[4].c);
    end
  end

  // ---------------- stage G: full product
  logic signed [PW-1:0] g_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[6] <= side_r[5];
      g_p_r     <= PW'(f_c_r) * PW'(f_gs_r);
    end
  end

  // ---------------- stage H: add rounding bias
  logic [5:0]           sh_w;
  logic signed [PW-1:0] h_sum_r;
  logic [5:0]           h_sh_r;

  assign sh_w = 6'd31 + 6'(side_r[6].ip) + 6'(side_r[6].inout_k);

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[7] <= side_r[6];
      h_sum_r   <= g_p_r + (PW'(1) <<< (sh_w - 6'd1));
      h_sh_r    <= sh_w;
    end
  end

  // ---------------- stage I: arithmetic shift
  logic signed [PW-1:0]  shifted_w;
  logic signed [TMW-1:0] i_term_r;

  assign shifted_w = h_sum_r >>> h_sh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[8] <= side_r[7];
      i_term_r  <= shifted_w[TMW-1:0];
    end
  end

  // ---------------- output register: start, end or damped value
  logic                  addc_w, spec_w;
  logic signed [TMW-1:0] res_w;
  logic                  out_vld_r;
  logic [OW-1:0]         out_val_r;

  assign spec_w = side_r[8].zero || side_r[8].full;
  assign addc_w = side_r[8].full || (!side_r[8].zero && !side_r[8].rising);
  assign res_w  = TMW'(side_r[8].b) + (addc_w ? TMW'(side_r[8].c) : '0)
                + (spec_w ? '0 : i_term_r);

  // valid chain through the evaluation stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= dv_vld;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
      out_vld_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= res_w[OW-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OTW'(out_val_r);

  // ---------------- assertions
  a_sin_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> d_addr_r <= (LD+1)'(SD))
    else $error("sine address beyond quarter wave");

  a_ip_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !side_r[1].zero && !side_r[1].full) |-> side_r[1].ip <= 4'd10)
    else $error("decay integer part out of range");

  a_u_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld && !dv_side.zero && !dv_side.full) |-> dv_q != '0)
    else $error("interior time gave zero quotient");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[NS-1]) && $stable(i_term_r))
    else $error("pipeline moved during stall");

endmodule
